[sv/ecpsm_pkg.sv]
// Shared types, constants and microcode for the elliptic-curve point multiplier.
`timescale 1ns / 1ps
package ecpsm_pkg;

    localparam int FIELD_BITS  = 32;
    localparam int SCALAR_BITS = 32;
    localparam int CMD_W       = 2;
    localparam int IN_W        = ((CMD_W + 4 * FIELD_BITS + SCALAR_BITS + 7) / 8) * 8;
    localparam int OUT_W       = 2 * FIELD_BITS;
    localparam int CNT_W       = $clog2(FIELD_BITS);
    localparam int PC_W        = 7;
    localparam int CFG_IDX_W   = 1;

    localparam logic [FIELD_BITS-1:0] MODULUS_RST = FIELD_BITS'(29);
    localparam logic [FIELD_BITS-1:0] CURVE_A_RST = FIELD_BITS'(4);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MODULUS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_CURVE_A = 1'b1;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_ADD  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DBL  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_MUL  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;

    typedef enum logic [4:0] {
        OP_MOV, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_EUC, OP_KSH, OP_SETH,
        OP_JMP, OP_JCMD, OP_JR1Z, OP_JKZ, OP_JKE, OP_JHAVE, OP_CALL, OP_RET,
        OP_FAILR0, OP_FAILNH, OP_DONEQ, OP_DONEP
    } uop_t;

    typedef enum logic [4:0] {
        R_PX, R_PY, R_QX, R_QY, R_AC, R_T0, R_T1, R_T2, R_T3,
        R_R0, R_R1, R_U0, R_U1, R_QT, R_MOD, R_ZERO, R_ONE
    } reg_id_t;

    typedef enum logic [1:0] {RES_Q, RES_P, RES_ZERO, RES_FAIL} res_kind_t;

    typedef enum logic [1:0] {S_IDLE, S_EXEC, S_WAIT, S_OUT} ctrl_state_t;

    typedef struct packed {
        uop_t              op;
        reg_id_t           dst;
        reg_id_t           sa;
        reg_id_t           sb;
        logic [PC_W-1:0]   tgt;
    } uinstr_t;

    typedef struct packed {
        logic      load_in;
        logic      exec;
        uop_t      op;
        reg_id_t   dst;
        reg_id_t   sa;
        reg_id_t   sb;
        logic      out_load;
        res_kind_t kind;
    } dp_cmd_t;

    typedef struct packed {
        logic [CMD_W-1:0] in_cmd;
        logic [CMD_W-1:0] cmd;
        logic             m_small;
        logic             r1_zero;
        logic             r0_one;
        logic             k_zero;
        logic             k_lsb;
        logic             have;
        logic             done;
        logic             out_free;
    } dp_stat_t;

    function automatic uinstr_t ui(uop_t op, reg_id_t d, reg_id_t a, reg_id_t b, int t);
        uinstr_t u;
        u.op  = op;
        u.dst = d;
        u.sa  = a;
        u.sb  = b;
        u.tgt = PC_W'(t);
        return u;
    endfunction

    // Microprogram: input reduction, dispatch, scalar loop, point add, point double
    function automatic uinstr_t ucode(logic [PC_W-1:0] pc);
        uinstr_t u;
        case (pc)
            7'd0:  u = ui(OP_DIV,   R_PX,   R_PX,   R_MOD,  0);
            7'd1:  u = ui(OP_DIV,   R_PY,   R_PY,   R_MOD,  0);
            7'd2:  u = ui(OP_DIV,   R_QX,   R_QX,   R_MOD,  0);
            7'd3:  u = ui(OP_DIV,   R_QY,   R_QY,   R_MOD,  0);
            7'd4:  u = ui(OP_DIV,   R_AC,   R_AC,   R_MOD,  0);
            7'd5:  u = ui(OP_JCMD,  R_ZERO, R_ZERO, R_ZERO, 6);
            7'd6:  u = ui(OP_JMP,   R_ZERO, R_ZERO, R_ZERO, 22);
            7'd7:  u = ui(OP_JMP,   R_ZERO, R_ZERO, R_ZERO, 24);
            // scalar multiply loop
            7'd8:  u = ui(OP_JKZ,   R_ZERO, R_ZERO, R_ZERO, 20);
            7'd9:  u = ui(OP_JKE,   R_ZERO, R_ZERO, R_ZERO, 16);
            7'd10: u = ui(OP_JHAVE, R_ZERO, R_ZERO, R_ZERO, 15);
            7'd11: u = ui(OP_MOV,   R_QX,   R_PX,   R_ZERO, 0);
            7'd12: u = ui(OP_MOV,   R_QY,   R_PY,   R_ZERO, 0);
            7'd13: u = ui(OP_SETH,  R_ZERO, R_ZERO, R_ZERO, 0);
            7'd14: u = ui(OP_JMP,   R_ZERO, R_ZERO, R_ZERO, 16);
            7'd15: u = ui(OP_CALL,  R_ZERO, R_ZERO, R_ZERO, 26);
            7'd16: u = ui(OP_KSH,   R_ZERO, R_ZERO, R_ZERO, 0);
            7'd17: u = ui(OP_JKZ,   R_ZERO, R_ZERO, R_ZERO, 8);
            7'd18: u = ui(OP_CALL,  R_ZERO, R_ZERO, R_ZERO, 48);
            7'd19: u = ui(OP_JMP,   R_ZERO, R_ZERO, R_ZERO, 8);
            7'd20: u = ui(OP_FAILNH, R_ZERO, R_ZERO, R_ZERO, 0);
            7'd21: u = ui(OP_DONEQ, R_ZERO, R_ZERO, R_ZERO, 0);
            7'd22: u = ui(OP_CALL,  R_ZERO, R_ZERO, R_ZERO, 26);
            7'd23: u = ui(OP_DONEQ, R_ZERO, R_ZERO, R_ZERO, 0);
            7'd24: u = ui(OP_CALL,  R_ZERO, R_ZERO, R_ZERO, 48);
            7'd25: u = ui(OP_DONEP, R_ZERO, R_ZERO, R_ZERO, 0);
            // point add: Q <= P + Q
            7'd26: u = ui(OP_SUB,   R_T0,   R_QX,   R_PX,   0);
            7'd27: u = ui(OP_MOV,   R_R0,   R_MOD,  R_ZERO, 0);
            7'd28: u = ui(OP_MOV,   R_R1,   R_T0,   R_ZERO, 0);
            7'd29: u = ui(OP_MOV,   R_U0,   R_ZERO, R_ZERO, 0);
            7'd30: u = ui(OP_MOV,   R_U1,   R_ONE,  R_ZERO, 0);
            7'd31: u = ui(OP_JR1Z,  R_ZERO, R_ZERO, R_ZERO, 37);
            7'd32: u = ui(OP_DIV,   R_T2,   R_R0,   R_R1,   0);
            7'd33: u = ui(OP_MUL,   R_T3,   R_QT,   R_U1,   0);
            7'd34: u = ui(OP_SUB,   R_T3,   R_U0,   R_T3,   0);
            7'd35: u = ui(OP_EUC,   R_ZERO, R_ZERO, R_ZERO, 0);
            7'd36: u = ui(OP_JMP,   R_ZERO, R_ZERO, R_ZERO, 31);
            7'd37: u = ui(OP_FAILR0, R_ZERO, R_ZERO, R_ZERO, 0);
            7'd38: u = ui(OP_SUB,   R_T1,   R_QY,   R_PY,   0);
            7'd39: u = ui(OP_MUL,   R_T1,   R_T1,   R_U0,   0);
            7'd40: u = ui(OP_MUL,   R_T2,   R_T1,   R_T1,   0);
            7'd41: u = ui(OP_SUB,   R_T2,   R_T2,   R_PX,   0);
            7'd42: u = ui(OP_SUB,   R_T2,   R_T2,   R_QX,   0);
            7'd43: u = ui(OP_SUB,   R_T3,   R_PX,   R_T2,   0);
            7'd44: u = ui(OP_MUL,   R_T3,   R_T1,   R_T3,   0);
            7'd45: u = ui(OP_SUB,   R_QY,   R_T3,   R_PY,   0);
            7'd46: u = ui(OP_MOV,   R_QX,   R_T2,   R_ZERO, 0);
            7'd47: u = ui(OP_RET,   R_ZERO, R_ZERO, R_ZERO, 0);
            // point double: P <= 2P
            7'd48: u = ui(OP_ADD,   R_T0,   R_PY,   R_PY,   0);
            7'd49: u = ui(OP_MOV,   R_R0,   R_MOD,  R_ZERO, 0);
            7'd50: u = ui(OP_MOV,   R_R1,   R_T0,   R_ZERO, 0);
            7'd51: u = ui(OP_MOV,   R_U0,   R_ZERO, R_ZERO, 0);
            7'd52: u = ui(OP_MOV,   R_U1,   R_ONE,  R_ZERO, 0);
            7'd53: u = ui(OP_JR1Z,  R_ZERO, R_ZERO, R_ZERO, 59);
            7'd54: u = ui(OP_DIV,   R_T2,   R_R0,   R_R1,   0);
            7'd55: u = ui(OP_MUL,   R_T3,   R_QT,   R_U1,   0);
            7'd56: u = ui(OP_SUB,   R_T3,   R_U0,   R_T3,   0);
            7'd57: u = ui(OP_EUC,   R_ZERO, R_ZERO, R_ZERO, 0);
            7'd58: u = ui(OP_JMP,   R_ZERO, R_ZERO, R_ZERO, 53);
            7'd59: u = ui(OP_FAILR0, R_ZERO, R_ZERO, R_ZERO, 0);
            7'd60: u = ui(OP_MUL,   R_T1,   R_PX,   R_PX,   0);
            7'd61: u = ui(OP_ADD,   R_T2,   R_T1,   R_T1,   0);
            7'd62: u = ui(OP_ADD,   R_T2,   R_T2,   R_T1,   0);
            7'd63: u = ui(OP_ADD,   R_T2,   R_T2,   R_AC,   0);
            7'd64: u = ui(OP_MUL,   R_T1,   R_T2,   R_U0,   0);
            7'd65: u = ui(OP_MUL,   R_T2,   R_T1,   R_T1,   0);
            7'd66: u = ui(OP_ADD,   R_T3,   R_PX,   R_PX,   0);
            7'd67: u = ui(OP_SUB,   R_T2,   R_T2,   R_T3,   0);
            7'd68: u = ui(OP_SUB,   R_T3,   R_PX,   R_T2,   0);
            7'd69: u = ui(OP_MUL,   R_T3,   R_T1,   R_T3,   0);
            7'd70: u = ui(OP_SUB,   R_PY,   R_T3,   R_PY,   0);
            7'd71: u = ui(OP_MOV,   R_PX,   R_T2,   R_ZERO, 0);
            7'd72: u = ui(OP_RET,   R_ZERO, R_ZERO, R_ZERO, 0);
            default: u = ui(OP_DONEQ, R_ZERO, R_ZERO, R_ZERO, 0);
        endcase
        return u;
    endfunction

endpackage

[sv/ecpsm_ctrl.sv]
// Microcode sequencer: fetches instructions, resolves branches and calls.
`timescale 1ns / 1ps
module ecpsm_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  ecpsm_pkg::dp_stat_t stat,
    output ecpsm_pkg::dp_cmd_t  cmd
);
    import ecpsm_pkg::*;

    ctrl_state_t     state_reg, state_next;
    logic [PC_W-1:0] pc_reg, pc_next;
    logic [PC_W-1:0] ret_reg, ret_next;
    res_kind_t       kind_reg, kind_next;
    uinstr_t         uin;
    logic [PC_W-1:0] pc_inc;

    assign uin    = ucode(pc_reg);
    assign pc_inc = pc_reg + 1'b1;

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pc_reg    <= '0;
            ret_reg   <= '0;
            kind_reg  <= RES_ZERO;
        end
        else
        begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
            ret_reg   <= ret_next;
            kind_reg  <= kind_next;
        end
    end

    // next state, program counter, return address and result kind
    always_comb
    begin
        state_next = state_reg;
        pc_next    = pc_reg;
        ret_next   = ret_reg;
        kind_next  = kind_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (stat.in_cmd == CMD_NONE)
                    begin
                        kind_next  = RES_ZERO;
                        state_next = S_OUT;
                    end
                    else if (stat.m_small)
                    begin
                        kind_next  = RES_FAIL;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        pc_next    = '0;
                        state_next = S_EXEC;
                    end
                end
            end
            S_EXEC:
            begin
                pc_next = pc_inc;
                case (uin.op)
                    OP_MUL, OP_DIV:
                    begin
                        pc_next    = pc_reg;
                        state_next = S_WAIT;
                    end
                    OP_JMP:   pc_next = uin.tgt;
                    OP_JCMD:  pc_next = uin.tgt + PC_W'(stat.cmd);
                    OP_JR1Z:  if (stat.r1_zero) pc_next = uin.tgt;
                    OP_JKZ:   if (stat.k_zero) pc_next = uin.tgt;
                    OP_JKE:   if (!stat.k_lsb) pc_next = uin.tgt;
                    OP_JHAVE: if (stat.have) pc_next = uin.tgt;
                    OP_CALL:
                    begin
                        ret_next = pc_inc;
                        pc_next  = uin.tgt;
                    end
                    OP_RET:   pc_next = ret_reg;
                    OP_FAILR0:
                    begin
                        if (!stat.r0_one)
                        begin
                            kind_next  = RES_FAIL;
                            state_next = S_OUT;
                        end
                    end
                    OP_FAILNH:
                    begin
                        if (!stat.have)
                        begin
                            kind_next  = RES_FAIL;
                            state_next = S_OUT;
                        end
                    end
                    OP_DONEQ:
                    begin
                        kind_next  = RES_Q;
                        state_next = S_OUT;
                    end
                    OP_DONEP:
                    begin
                        kind_next  = RES_P;
                        state_next = S_OUT;
                    end
                    default: ;
                endcase
            end
            S_WAIT:
            begin
                if (stat.done)
                begin
                    pc_next    = pc_inc;
                    state_next = S_EXEC;
                end
            end
            S_OUT:
            begin
                if (stat.out_free)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // datapath commands
    always_comb
    begin
        in_ready     = 1'b0;
        cmd.load_in  = 1'b0;
        cmd.exec     = 1'b0;
        cmd.op       = uin.op;
        cmd.dst      = uin.dst;
        cmd.sa       = uin.sa;
        cmd.sb       = uin.sb;
        cmd.out_load = 1'b0;
        cmd.kind     = kind_reg;
        case (state_reg)
            S_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.load_in = in_valid;
            end
            S_EXEC:  cmd.exec     = 1'b1;
            S_OUT:   cmd.out_load = stat.out_free;
            default: ;
        endcase
    end

endmodule

[sv/ecpsm_dp.sv]
// Datapath: operand registers, modular add/sub, serial multiplier and divider, output beat.
`timescale 1ns / 1ps
module ecpsm_dp
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic [ecpsm_pkg::IN_W-1:0]            in_data,
    input  logic                                  cfg_wr_en,
    input  logic [ecpsm_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [ecpsm_pkg::FIELD_BITS-1:0]      cfg_data,
    input  ecpsm_pkg::dp_cmd_t                    cmd,
    output ecpsm_pkg::dp_stat_t                   stat,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [ecpsm_pkg::OUT_W-1:0]           out_data,
    output logic                                  out_flag
);
    import ecpsm_pkg::*;

    localparam int FB = FIELD_BITS;

    logic [FB-1:0] modulus_reg, curve_a_reg;
    logic [FB-1:0] px_reg, py_reg, qx_reg, qy_reg, ac_reg;
    logic [FB-1:0] t0_reg, t1_reg, t2_reg, t3_reg;
    logic [FB-1:0] r0_reg, r1_reg, u0_reg, u1_reg, qt_reg;
    logic [SCALAR_BITS-1:0] k_reg;
    logic [CMD_W-1:0] cmd_reg;
    logic          have_reg;

    // serial unit
    logic          busy_reg, done_reg, isdiv_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [FB-1:0] ma_reg, mb_reg, acc_reg;
    reg_id_t       mdst_reg;

    logic          out_valid_reg;
    logic [FB-1:0] rx_reg, ry_reg;
    logic          flag_reg;

    logic [FB-1:0] opa, opb, alu_res;
    logic [FB-1:0] mul_r2, mul_r3;
    logic [FB:0]   div_sh;
    logic          div_ge;
    logic [FB-1:0] div_rem, div_q, div_qr;
    logic          last_it, start, wr_en;
    reg_id_t       wr_id;
    logic [FB-1:0] wr_val;

    function automatic logic [FB-1:0] mod_add(logic [FB-1:0] a, logic [FB-1:0] b,
                                              logic [FB-1:0] m);
        logic [FB:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, m})
            s = s - {1'b0, m};
        return s[FB-1:0];
    endfunction

    function automatic logic [FB-1:0] mod_sub(logic [FB-1:0] a, logic [FB-1:0] b,
                                              logic [FB-1:0] m);
        logic [FB-1:0] d;
        d = a - b;
        if (a < b)
            d = d + m;
        return d;
    endfunction

    function automatic logic [FB-1:0] rd(reg_id_t id, logic [FB-1:0] px, logic [FB-1:0] py,
        logic [FB-1:0] qx, logic [FB-1:0] qy, logic [FB-1:0] ac, logic [FB-1:0] t0,
        logic [FB-1:0] t1, logic [FB-1:0] t2, logic [FB-1:0] t3, logic [FB-1:0] r0,
        logic [FB-1:0] r1, logic [FB-1:0] u0, logic [FB-1:0] u1, logic [FB-1:0] qt,
        logic [FB-1:0] m);
        logic [FB-1:0] v;
        case (id)
            R_PX:    v = px;
            R_PY:    v = py;
            R_QX:    v = qx;
            R_QY:    v = qy;
            R_AC:    v = ac;
            R_T0:    v = t0;
            R_T1:    v = t1;
            R_T2:    v = t2;
            R_T3:    v = t3;
            R_R0:    v = r0;
            R_R1:    v = r1;
            R_U0:    v = u0;
            R_U1:    v = u1;
            R_QT:    v = qt;
            R_MOD:   v = m;
            R_ONE:   v = FB'(1);
            default: v = '0;
        endcase
        return v;
    endfunction

    // operand select
    assign opa = rd(cmd.sa, px_reg, py_reg, qx_reg, qy_reg, ac_reg, t0_reg, t1_reg, t2_reg,
                    t3_reg, r0_reg, r1_reg, u0_reg, u1_reg, qt_reg, modulus_reg);
    assign opb = rd(cmd.sb, px_reg, py_reg, qx_reg, qy_reg, ac_reg, t0_reg, t1_reg, t2_reg,
                    t3_reg, r0_reg, r1_reg, u0_reg, u1_reg, qt_reg, modulus_reg);

    // combinational ALU
    always_comb
    begin
        case (cmd.op)
            OP_ADD:  alu_res = mod_add(opa, opb, modulus_reg);
            OP_SUB:  alu_res = mod_sub(opa, opb, modulus_reg);
            default: alu_res = opa;
        endcase
    end

    // one multiplier bit (MSB first) and one restoring division step per cycle
    assign mul_r2  = mod_add(acc_reg, acc_reg, modulus_reg);
    assign mul_r3  = mb_reg[FB-1] ? mod_add(mul_r2, ma_reg, modulus_reg) : mul_r2;
    assign div_sh  = {acc_reg, ma_reg[FB-1]};
    assign div_ge  = div_sh >= {1'b0, mb_reg};
    assign div_rem = div_ge ? FB'(div_sh - {1'b0, mb_reg}) : div_sh[FB-1:0];
    assign div_q   = {ma_reg[FB-2:0], div_ge};
    assign div_qr  = (div_q >= modulus_reg) ? div_q - modulus_reg : div_q;
    assign last_it = busy_reg && (cnt_reg == CNT_W'(FB - 1));
    assign start   = cmd.exec && (cmd.op == OP_MUL || cmd.op == OP_DIV);

    // register write port
    always_comb
    begin
        wr_en  = 1'b0;
        wr_id  = cmd.dst;
        wr_val = alu_res;
        if (last_it)
        begin
            wr_en  = 1'b1;
            wr_id  = mdst_reg;
            wr_val = isdiv_reg ? div_rem : mul_r3;
        end
        else if (cmd.exec && (cmd.op == OP_MOV || cmd.op == OP_ADD || cmd.op == OP_SUB))
            wr_en = 1'b1;
    end

    // control flags of the serial unit, scalar state, configuration and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b0;
            done_reg    <= 1'b0;
            cnt_reg     <= '0;
            have_reg    <= 1'b0;
            modulus_reg <= MODULUS_RST;
            curve_a_reg <= CURVE_A_RST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            done_reg <= last_it;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (last_it)
                busy_reg <= 1'b0;
            else if (busy_reg)
                cnt_reg <= cnt_reg + 1'b1;
            if (cmd.load_in)
                have_reg <= 1'b0;
            else if (cmd.exec && cmd.op == OP_SETH)
                have_reg <= 1'b1;
            if (cfg_wr_en && cfg_index == CFG_MODULUS)
                modulus_reg <= cfg_data;
            if (cfg_wr_en && cfg_index == CFG_CURVE_A)
                curve_a_reg <= cfg_data;
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // operand registers, serial unit payload and output registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            cmd_reg <= in_data[CMD_W-1:0];
            px_reg  <= in_data[CMD_W +: FB];
            py_reg  <= in_data[CMD_W + FB +: FB];
            qx_reg  <= in_data[CMD_W + 2 * FB +: FB];
            qy_reg  <= in_data[CMD_W + 3 * FB +: FB];
            k_reg   <= in_data[CMD_W + 4 * FB +: SCALAR_BITS];
            ac_reg  <= curve_a_reg;
        end
        if (cmd.exec && cmd.op == OP_KSH)
            k_reg <= k_reg >> 1;
        if (cmd.exec && cmd.op == OP_EUC)
        begin
            r0_reg <= r1_reg;
            r1_reg <= t2_reg;
            u0_reg <= u1_reg;
            u1_reg <= t3_reg;
        end
        if (start)
        begin
            isdiv_reg <= (cmd.op == OP_DIV);
            mdst_reg  <= cmd.dst;
            ma_reg    <= opa;
            mb_reg    <= opb;
            acc_reg   <= '0;
        end
        else if (busy_reg)
        begin
            if (isdiv_reg)
            begin
                acc_reg <= div_rem;
                ma_reg  <= div_q;
            end
            else
            begin
                acc_reg <= mul_r3;
                mb_reg  <= mb_reg << 1;
            end
        end
        if (last_it && isdiv_reg)
            qt_reg <= div_qr;
        if (wr_en)
        begin
            case (wr_id)
                R_PX:    px_reg <= wr_val;
                R_PY:    py_reg <= wr_val;
                R_QX:    qx_reg <= wr_val;
                R_QY:    qy_reg <= wr_val;
                R_AC:    ac_reg <= wr_val;
                R_T0:    t0_reg <= wr_val;
                R_T1:    t1_reg <= wr_val;
                R_T2:    t2_reg <= wr_val;
                R_T3:    t3_reg <= wr_val;
                R_R0:    r0_reg <= wr_val;
                R_R1:    r1_reg <= wr_val;
                R_U0:    u0_reg <= wr_val;
                R_U1:    u1_reg <= wr_val;
                default: ;
            endcase
        end
        if (cmd.out_load)
        begin
            case (cmd.kind)
                RES_Q:
                begin
                    rx_reg   <= qx_reg;
                    ry_reg   <= qy_reg;
                    flag_reg <= 1'b0;
                end
                RES_P:
                begin
                    rx_reg   <= px_reg;
                    ry_reg   <= py_reg;
                    flag_reg <= 1'b0;
                end
                RES_FAIL:
                begin
                    rx_reg   <= '0;
                    ry_reg   <= '0;
                    flag_reg <= 1'b1;
                end
                default:
                begin
                    rx_reg   <= '0;
                    ry_reg   <= '0;
                    flag_reg <= 1'b0;
                end
            endcase
        end
    end

    // status to the sequencer
    assign stat.in_cmd   = in_data[CMD_W-1:0];
    assign stat.cmd      = cmd_reg;
    assign stat.m_small  = modulus_reg < FB'(2);
    assign stat.r1_zero  = (r1_reg == '0);
    assign stat.r0_one   = (r0_reg == FB'(1));
    assign stat.k_zero   = (k_reg == '0);
    assign stat.k_lsb    = k_reg[0];
    assign stat.have     = have_reg;
    assign stat.done     = done_reg;
    assign stat.out_free = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_data  = {ry_reg, rx_reg};
    assign out_flag  = flag_reg;

endmodule

[sv/ecc_point_scalar_multiply.sv]
// Top level: affine elliptic-curve add, double and scalar multiply over a prime field.
// Add and double each invert one field element by the extended Euclid loop; multiply
// reduces its inputs modulo the modulus first and then runs up to 62 point adds and doubles.
// Multiplies and divides run on the bit-serial unit; other steps use the combinational ALU.
// One item at a time; the next beat is taken once the result sits in the output register.
// rst_n is asynchronous, active low; modulus resets to 29 and curve_a to 4.
`timescale 1ns / 1ps
module ecc_point_scalar_multiply
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // cmd, px, py, qx, qy, scalar from bit 0 up, zero padded
    input  logic [ecpsm_pkg::IN_W-1:0]            s_axis_tdata,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // rx, ry from bit 0 up
    output logic [ecpsm_pkg::OUT_W-1:0]           m_axis_tdata,
    // failure: no inverse, modulus below 2, or zero scalar in a multiply
    output logic                                  m_axis_tuser,
    input  logic                                  cfg_wr_en,
    input  logic [ecpsm_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [ecpsm_pkg::FIELD_BITS-1:0]      cfg_data
);
    import ecpsm_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    ecpsm_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    ecpsm_dp u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (s_axis_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .out_flag  (m_axis_tuser)
    );

endmodule

[sv/ecpsm_chk.sv]
// Port-level checker for the point multiplier, bound to the top level.
`timescale 1ns / 1ps
module ecpsm_chk
(
    input logic                                  clk,
    input logic                                  rst_n,
    input logic                                  s_axis_tvalid,
    input logic                                  s_axis_tready,
    input logic                                  m_axis_tvalid,
    input logic                                  m_axis_tready,
    input logic [ecpsm_pkg::OUT_W-1:0]           m_axis_tdata,
    input logic                                  m_axis_tuser
);
    import ecpsm_pkg::*;

    // a flagged result carries zero coordinates
    a_flag_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
        else $error("flagged beat with nonzero coordinates");

    // the block is busy right after taking a beat
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input ready right after accept");

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("output beat changed while stalled");

endmodule

bind ecc_point_scalar_multiply ecpsm_chk u_chk (.*);
